### sv/slt_pkg.sv
// ----------------------------------------------------------------------------
// slt_pkg
// Shared types and constants for the sorted leaf table unit.
// ----------------------------------------------------------------------------
package slt_pkg;

    localparam int MAX_ENTRIES_DEF = 16;
    localparam int VALUE_BITS_DEF  = 64;
    localparam int KEY_W           = 32;
    localparam int POS_W           = 5;
    localparam int RIDX_W          = 4;

    typedef enum logic [1:0] {
        OP_FIND   = 2'd0,
        OP_INSERT = 2'd1,
        OP_READ   = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STS_OK    = 2'd0,
        STS_FULL  = 2'd1,
        STS_RANGE = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_COMPARE,
        S_SHIFT,
        S_READ_WAIT,
        S_DONE
    } state_t;

endpackage

### sv/sorted_leaf_table_unit.sv
// ----------------------------------------------------------------------------
// sorted_leaf_table_unit
// Key/value table of fixed capacity kept in ascending key order in one memory.
// ----------------------------------------------------------------------------
// A find is a binary search, one memory read and one compare per probe, that ends
// early when a probe hits; an insert then moves the entries from the position up
// to the end one slot up and writes the new one, unless the table is full; a read
// fetches one entry; clear resets the count. One word is in work at a time: the next
// is taken once the result word is issued, which waits while the last one stalls.
// Reset clears the entry count and handshake state; memory contents stay undefined.
module sorted_leaf_table_unit #(
    parameter int MAX_ENTRIES = slt_pkg::MAX_ENTRIES_DEF,
    parameter int VALUE_BITS  = slt_pkg::VALUE_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [1:0]                  opcode,
    input  logic [slt_pkg::KEY_W-1:0]   search_key,
    input  logic [VALUE_BITS-1:0]       entry_value,
    input  logic [slt_pkg::RIDX_W-1:0]  read_index,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [slt_pkg::POS_W-1:0]   position,
    output logic                        hit,
    output logic [slt_pkg::KEY_W-1:0]   out_key,
    output logic [VALUE_BITS-1:0]       out_value,
    output logic [slt_pkg::POS_W-1:0]   entry_count,
    output logic [1:0]                  status
);
    import slt_pkg::*;

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int ENT_W = KEY_W + VALUE_BITS;

    logic [ENT_W-1:0]      entry_mem [MAX_ENTRIES];
    logic [ENT_W-1:0]      mem_rdata_reg;
    logic                  mem_we;
    logic                  rd_en;
    logic [IDX_W-1:0]      mem_waddr;
    logic [IDX_W-1:0]      mem_raddr;
    logic [ENT_W-1:0]      mem_wdata;

    state_t                state_reg, state_next;
    op_t                   op_reg, op_next;
    logic [KEY_W-1:0]      key_reg, key_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic [RIDX_W-1:0]     ridx_reg, ridx_next;
    logic [CNT_W-1:0]      lo_reg, lo_next;
    logic [CNT_W-1:0]      hi_reg, hi_next;
    logic [CNT_W-1:0]      mid_reg, mid_next;
    logic [CNT_W-1:0]      cur_reg, cur_next;
    logic                  pend_reg, pend_next;
    logic                  hit_reg, hit_next;
    logic [CNT_W-1:0]      used_count_reg, used_count_next;
    logic [KEY_W-1:0]      res_key_reg, res_key_next;
    logic [VALUE_BITS-1:0] res_val_reg, res_val_next;
    status_t               res_status_reg, res_status_next;

    logic                  out_valid_reg, out_valid_next;
    logic [POS_W-1:0]      out_pos_reg, out_pos_next;
    logic                  out_hit_reg, out_hit_next;
    logic [KEY_W-1:0]      out_key_reg, out_key_next;
    logic [VALUE_BITS-1:0] out_val_reg, out_val_next;
    logic [POS_W-1:0]      out_cnt_reg, out_cnt_next;
    status_t               out_status_reg, out_status_next;

    logic [CNT_W:0]        mid_sum;
    logic [CNT_W-1:0]      mid_calc;
    logic [CNT_W-1:0]      cur_inc;
    logic [CNT_W-1:0]      cur_dec;
    logic [KEY_W-1:0]      rd_key;
    logic [VALUE_BITS-1:0] rd_val;
    logic                  read_ok;
    logic                  search_done;

    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid_calc = mid_sum[CNT_W:1];
    assign cur_inc  = cur_reg + CNT_W'(1);
    assign cur_dec  = cur_reg - CNT_W'(1);
    assign rd_key   = mem_rdata_reg[ENT_W-1 -: KEY_W];
    assign rd_val   = mem_rdata_reg[VALUE_BITS-1:0];
    assign read_ok  = (32'(read_index) < 32'(used_count_reg))
                   && (32'(read_index) < 32'(MAX_ENTRIES));

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            entry_mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            mem_rdata_reg <= entry_mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            used_count_reg <= '0;
            pend_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            used_count_reg <= used_count_next;
            pend_reg       <= pend_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        val_reg        <= val_next;
        ridx_reg       <= ridx_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mid_reg        <= mid_next;
        cur_reg        <= cur_next;
        hit_reg        <= hit_next;
        res_key_reg    <= res_key_next;
        res_val_reg    <= res_val_next;
        res_status_reg <= res_status_next;
        out_pos_reg    <= out_pos_next;
        out_hit_reg    <= out_hit_next;
        out_key_reg    <= out_key_next;
        out_val_reg    <= out_val_next;
        out_cnt_reg    <= out_cnt_next;
        out_status_reg <= out_status_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        val_next        = val_reg;
        ridx_next       = ridx_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        cur_next        = cur_reg;
        pend_next       = pend_reg;
        hit_next        = hit_reg;
        used_count_next = used_count_reg;
        res_key_next    = res_key_reg;
        res_val_next    = res_val_reg;
        res_status_next = res_status_reg;
        out_pos_next    = out_pos_reg;
        out_hit_next    = out_hit_reg;
        out_key_next    = out_key_reg;
        out_val_next    = out_val_reg;
        out_cnt_next    = out_cnt_reg;
        out_status_next = out_status_reg;
        out_valid_next  = out_valid_reg && out_stall;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_wdata       = '0;
        rd_en           = 1'b0;
        mem_raddr       = '0;
        search_done     = 1'b0;
        in_stall        = (state_reg != S_IDLE);

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next         = op_t'(opcode);
                    key_next        = search_key;
                    val_next        = entry_value;
                    ridx_next       = read_index;
                    lo_next         = '0;
                    hi_next         = used_count_reg;
                    hit_next        = 1'b0;
                    res_key_next    = '0;
                    res_val_next    = '0;
                    res_status_next = STS_OK;
                    case (op_t'(opcode))
                        OP_FIND, OP_INSERT:
                        begin
                            state_next = S_SEARCH;
                        end
                        OP_READ:
                        begin
                            if (read_ok)
                            begin
                                rd_en      = 1'b1;
                                mem_raddr  = IDX_W'(read_index);
                                state_next = S_READ_WAIT;
                            end
                            else
                            begin
                                res_status_next = STS_RANGE;
                                state_next      = S_DONE;
                            end
                        end
                        default:
                        begin
                            used_count_next = '0;
                            state_next      = S_DONE;
                        end
                    endcase
                end
            end
            S_SEARCH:
            begin
                if (lo_reg == hi_reg)
                begin
                    search_done = 1'b1;
                end
                else
                begin
                    mid_next   = mid_calc;
                    rd_en      = 1'b1;
                    mem_raddr  = mid_calc[IDX_W-1:0];
                    state_next = S_COMPARE;
                end
            end
            S_COMPARE:
            begin
                if (key_reg == rd_key)
                begin
                    hit_next    = 1'b1;
                    lo_next     = mid_reg;
                    search_done = 1'b1;
                end
                else if (key_reg < rd_key)
                begin
                    hi_next    = mid_reg;
                    state_next = S_SEARCH;
                end
                else
                begin
                    lo_next    = mid_reg + CNT_W'(1);
                    state_next = S_SEARCH;
                end
            end
            S_SHIFT:
            begin
                if (pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = cur_inc[IDX_W-1:0];
                    mem_wdata = mem_rdata_reg;
                end
                if (cur_reg != lo_reg)
                begin
                    rd_en     = 1'b1;
                    mem_raddr = cur_dec[IDX_W-1:0];
                    cur_next  = cur_dec;
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        mem_we          = 1'b1;
                        mem_waddr       = lo_reg[IDX_W-1:0];
                        mem_wdata       = {key_reg, val_reg};
                        used_count_next = used_count_reg + CNT_W'(1);
                        state_next      = S_DONE;
                    end
                end
            end
            S_READ_WAIT:
            begin
                res_key_next = rd_key;
                res_val_next = rd_val;
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_hit_next    = hit_reg;
                    out_key_next    = res_key_reg;
                    out_val_next    = res_val_reg;
                    out_cnt_next    = POS_W'(used_count_reg);
                    out_status_next = res_status_reg;
                    case (op_reg)
                        OP_FIND, OP_INSERT: out_pos_next = POS_W'(lo_reg);
                        OP_READ:            out_pos_next = POS_W'(ridx_reg);
                        default:            out_pos_next = '0;
                    endcase
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (search_done)
        begin
            if (op_reg != OP_INSERT)
            begin
                state_next = S_DONE;
            end
            else if (used_count_reg >= CNT_W'(MAX_ENTRIES))
            begin
                res_status_next = STS_FULL;
                state_next      = S_DONE;
            end
            else
            begin
                cur_next   = used_count_reg;
                pend_next  = 1'b0;
                state_next = S_SHIFT;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign position    = out_pos_reg;
    assign hit         = out_hit_reg;
    assign out_key     = out_key_reg;
    assign out_value   = out_val_reg;
    assign entry_count = out_cnt_reg;
    assign status      = out_status_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(used_count_reg) <= MAX_ENTRIES)
        else $error("entry count exceeds capacity");

    a_shift_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && rd_en) |-> (mem_waddr != mem_raddr))
        else $error("shift reads and writes the same entry");

    a_search_window: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEARCH) |-> (lo_reg <= hi_reg && hi_reg <= used_count_reg))
        else $error("search window out of bounds");

    a_count_change: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(used_count_reg) |-> ($past(state_reg) == S_SHIFT
                                      || $past(state_reg) == S_IDLE))
        else $error("entry count changed outside insert or clear");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_DONE))
        else $error("result word issued outside completion");
`endif

endmodule

### tb/sv/tb_sorted_leaf_table_unit.sv
// ----------------------------------------------------------------------------
// tb_sorted_leaf_table_unit
// Self-checking testbench for the sorted leaf table unit. A local model of
// the sorted key/value table predicts every result word, and a checker
// compares each one field by field with the oldest prediction. Directed
// tests cover the empty table, filling to capacity with duplicate and extreme
// keys, refused inserts, range errors and clear. Random traffic follows,
// with bursty input, receiver stalls, one long receiver hold-off and drains.
// ----------------------------------------------------------------------------
module tb_sorted_leaf_table_unit;

    import slt_pkg::*;

    localparam int LEAF_SIZE   = MAX_ENTRIES_DEF;
    localparam int CYCLE_LIMIT = 600000;

    typedef struct {
        logic [POS_W-1:0]          position;
        logic                      hit;
        logic [KEY_W-1:0]          key;
        logic [VALUE_BITS_DEF-1:0] value;
        logic [POS_W-1:0]          count;
        logic [1:0]                status;
    } leaf_result_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic [1:0]                opcode = OP_FIND;
    logic [KEY_W-1:0]          search_key = '0;
    logic [VALUE_BITS_DEF-1:0] entry_value = '0;
    logic [RIDX_W-1:0]         read_index = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic [POS_W-1:0]          position;
    logic                      hit;
    logic [KEY_W-1:0]          out_key;
    logic [VALUE_BITS_DEF-1:0] out_value;
    logic [POS_W-1:0]          entry_count;
    logic [1:0]                status;

    logic [KEY_W-1:0]          leaf_keys [LEAF_SIZE];
    logic [VALUE_BITS_DEF-1:0] leaf_values [LEAF_SIZE];
    int                        leaf_count = 0;
    leaf_result_t              pending_results [$];

    int errors = 0;
    int cycle_count = 0;
    bit sender_gaps = 1'b1;
    bit receiver_stalls = 1'b1;
    int burst_left = 0;
    int hold_request = 0;
    int hold_left = 0;
    int segment_left = 0;
    bit segment_stall = 1'b0;

    sorted_leaf_table_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .opcode      (opcode),
        .search_key  (search_key),
        .entry_value (entry_value),
        .read_index  (read_index),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .position    (position),
        .hit         (hit),
        .out_key     (out_key),
        .out_value   (out_value),
        .entry_count (entry_count),
        .status      (status)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Applies one word to the local table and returns the result it yields.
    function automatic leaf_result_t apply_word(input op_t op, input logic [KEY_W-1:0] key,
                                                input logic [VALUE_BITS_DEF-1:0] val,
                                                input logic [RIDX_W-1:0] idx);
        leaf_result_t r;
        int lo;
        int hi;
        int mid;
        int slot;
        bit found;
        r.position = '0;
        r.hit      = 1'b0;
        r.key      = '0;
        r.value    = '0;
        r.status   = STS_OK;
        lo = 0;
        hi = leaf_count;
        found = 1'b0;
        if (op == OP_FIND || op == OP_INSERT)
        begin
            while (lo != hi && !found)
            begin
                mid = (lo + hi) / 2;
                if (key == leaf_keys[mid])
                begin
                    found = 1'b1;
                    lo = mid;
                end
                else if (key < leaf_keys[mid])
                    hi = mid;
                else
                    lo = mid + 1;
            end
            r.position = POS_W'(lo);
            r.hit = found;
        end
        case (op)
            OP_INSERT:
            begin
                if (leaf_count >= LEAF_SIZE)
                    r.status = STS_FULL;
                else
                begin
                    for (slot = leaf_count; slot > lo; slot--)
                    begin
                        leaf_keys[slot]   = leaf_keys[slot - 1];
                        leaf_values[slot] = leaf_values[slot - 1];
                    end
                    leaf_keys[lo]   = key;
                    leaf_values[lo] = val;
                    leaf_count++;
                end
            end
            OP_READ:
            begin
                r.position = POS_W'(idx);
                if (idx < leaf_count)
                begin
                    r.key   = leaf_keys[idx];
                    r.value = leaf_values[idx];
                end
                else
                    r.status = STS_RANGE;
            end
            OP_CLEAR:
                leaf_count = 0;
            default:
            begin
            end
        endcase
        r.count = POS_W'(leaf_count);
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [63:0] want,
                                   input logic [63:0] got);
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    endtask

    always @(posedge clk)
    begin : result_check
        leaf_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t: result word with none expected, expected nothing, actual pos %0d",
                         $time, position);
            end
            else
            begin
                want = pending_results.pop_front();
                if (position !== want.position)
                    report_mismatch("position", 64'(want.position), 64'(position));
                if (hit !== want.hit)
                    report_mismatch("hit", 64'(want.hit), 64'(hit));
                if (out_key !== want.key)
                    report_mismatch("out_key", 64'(want.key), 64'(out_key));
                if (out_value !== want.value)
                    report_mismatch("out_value", want.value, out_value);
                if (entry_count !== want.count)
                    report_mismatch("entry_count", 64'(want.count), 64'(entry_count));
                if (status !== want.status)
                    report_mismatch("status", 64'(want.status), 64'(status));
            end
        end
    end

    always @(negedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (!receiver_stalls)
            out_stall <= 1'b0;
        else
        begin
            if (segment_left == 0)
            begin
                segment_stall = ($urandom_range(0, 2) == 0);
                segment_left = segment_stall ? $urandom_range(1, 5) : $urandom_range(1, 30);
            end
            segment_left--;
            out_stall <= segment_stall;
        end
    end

    task automatic pause_input(input int cycles);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    task automatic send_word(input op_t op, input logic [KEY_W-1:0] key,
                             input logic [VALUE_BITS_DEF-1:0] val,
                             input logic [RIDX_W-1:0] idx);
        if (sender_gaps && burst_left == 0)
        begin
            pause_input($urandom_range(1, 6));
            burst_left = $urandom_range(1, 24);
        end
        else
            @(negedge clk);
        if (burst_left > 0)
            burst_left--;
        in_valid    <= 1'b1;
        opcode      <= op;
        search_key  <= key;
        entry_value <= val;
        read_index  <= idx;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_results.push_back(apply_word(op, key, val, idx));
    endtask

    task automatic wait_for_results();
        pause_input(0);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom_range(0, 31);
            4:          return 32'hFFFF_FFFF - $urandom_range(0, 3);
            5, 6:       return (leaf_count > 0) ? leaf_keys[$urandom_range(0, leaf_count - 1)]
                                                : $urandom;
            default:    return $urandom;
        endcase
    endfunction

    function automatic logic [VALUE_BITS_DEF-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic test_empty_table();
        send_word(OP_FIND, 32'h0000_0000, '1, 4'd0);
        send_word(OP_FIND, 32'hFFFF_FFFF, '0, 4'd15);
        send_word(OP_READ, $urandom, pick_value(), 4'd0);
        send_word(OP_READ, $urandom, pick_value(), 4'd15);
        wait_for_results();
    endtask

    task automatic test_fill_to_capacity();
        logic [KEY_W-1:0] fill_keys [LEAF_SIZE] = '{
            32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000, 32'h0000_0007,
            32'h0000_0007, 32'h0000_0007, 32'h0000_0001, 32'hFFFF_FFFE,
            32'h4000_0000, 32'h0000_0003, 32'h0000_0002, 32'h0000_0009,
            32'h0000_0001, 32'h1234_5678, 32'hC000_0000, 32'h0000_0006};
        int n;
        for (n = 0; n < LEAF_SIZE; n++)
            send_word(OP_INSERT, fill_keys[n], (n % 3 == 0) ? '0 : (n % 3 == 1) ? '1
                      : {$urandom, $urandom}, RIDX_W'($urandom_range(0, 15)));
        send_word(OP_INSERT, 32'h0000_0007, '1, 4'd3);
        send_word(OP_INSERT, 32'h0000_0005, '1, 4'd12);
        send_word(OP_FIND, 32'h0000_0007, '0, 4'd0);
        send_word(OP_READ, '1, '1, 4'd0);
        send_word(OP_READ, '0, '0, 4'd15);
        wait_for_results();
    endtask

    task automatic test_clear();
        send_word(OP_CLEAR, $urandom, pick_value(), RIDX_W'($urandom_range(0, 15)));
        send_word(OP_READ, $urandom, pick_value(), 4'd0);
        wait_for_results();
    endtask

    task automatic test_long_hold_off();
        int n;
        sender_gaps = 1'b0;
        hold_request = 300;
        for (n = 0; n < 12; n++)
            send_word(($urandom_range(0, 1) == 0) ? OP_INSERT : OP_FIND, pick_key(),
                      pick_value(), RIDX_W'($urandom_range(0, 15)));
        wait_for_results();
        sender_gaps = 1'b1;
    endtask

    task automatic test_random_traffic(input int words);
        int n;
        int roll;
        op_t op;
        logic [RIDX_W-1:0] idx;
        for (n = 0; n < words; n++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 3)
                op = OP_CLEAR;
            else if (roll < 45)
                op = OP_INSERT;
            else if (roll < 75)
                op = OP_FIND;
            else
                op = OP_READ;
            idx = RIDX_W'($urandom_range(0, 15));
            if (op == OP_READ && leaf_count > 0 && $urandom_range(0, 1) == 0)
                idx = RIDX_W'($urandom_range(0, leaf_count - 1));
            send_word(op, pick_key(), pick_value(), idx);
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_table();
        test_fill_to_capacity();
        test_clear();
        test_long_hold_off();

        sender_gaps = 1'b1;
        receiver_stalls = 1'b1;
        test_random_traffic(450);
        wait_for_results();
        sender_gaps = 1'b0;
        receiver_stalls = 1'b0;
        test_random_traffic(450);
        sender_gaps = 1'b1;
        test_random_traffic(450);
        wait_for_results();
        sender_gaps = 1'b0;
        receiver_stalls = 1'b1;
        test_random_traffic(460);

        wait_for_results();
        repeat (64) @(posedge clk);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### filelist.f
sv/slt_pkg.sv
sv/sorted_leaf_table_unit.sv
tb/sv/tb_sorted_leaf_table_unit.sv
